// ----- rtl/core/ltc_pkg.sv -----
// Shared types, constants and helper functions for the letter trigram counter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ltc_pkg;
    localparam int ALPHABET_SIZE = 35;
    localparam int COUNT_BITS    = 32;
    localparam int CODE_BITS     = 6;
    localparam int PAIRS         = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int TRIS          = PAIRS * ALPHABET_SIZE;
    localparam int PAIR_AW       = $clog2(PAIRS);
    localparam int TRI_AW        = $clog2(TRIS);
    localparam int PCT_BITS      = 15;
    localparam int QUOT_BITS     = 16;
    localparam int DIVIDEND_BITS = COUNT_BITS + QUOT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [PCT_BITS-1:0] PCT_EMPTY_ROW = PCT_BITS'(25600 / ALPHABET_SIZE);
    localparam logic [PCT_BITS-1:0] PCT_FULL = PCT_BITS'(25600);
    localparam logic [7:0] LINE_END = 8'd10;

    typedef enum logic [1:0] {
        OP_FEED = 2'd0, OP_READ_TRI = 2'd1, OP_READ_PAIR = 2'd2, OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_TRIGRAM = 3'd0, ST_PAIR = 3'd1, ST_WAIT = 3'd2, ST_IGNORED = 3'd3,
        ST_READ_OK = 3'd4, ST_READ_ZERO = 3'd5, ST_RSV6 = 3'd6, ST_RSV7 = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0, PH_FIRST = 2'd1, PH_LINE = 2'd2, PH_RSV = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FEED_RD, S_FEED_WR, S_READ_RD, S_READ_DATA,
        S_DIV, S_OUT
    } state_t;

    // Command group from controller to datapath.
    typedef struct packed {
        logic capture;      // register the accepted word
        logic clear_step;   // write zeros at clear address and advance
        logic issue_read;   // present read addresses to the memories
        logic feed_write;   // write incremented counts, update letters
        logic read_latch;   // latch read data, start divide if needed
        logic div_step;     // one quotient bit
        logic load_out;     // result into output register
    } cmd_t;

    // Status group from datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic need_div;
        logic div_done;
    } stat_t;

    function automatic logic [CODE_BITS:0] letter_code(input logic [7:0] b);
        logic [CODE_BITS:0] c;
        c = {1'b1, {CODE_BITS{1'b0}}};
        if (b >= 8'd97 && b <= 8'd122) c = {1'b0, CODE_BITS'(b - 8'd97)};
        case (b)
            8'd165: c = {1'b0, CODE_BITS'(26)};
            8'd134: c = {1'b0, CODE_BITS'(27)};
            8'd169: c = {1'b0, CODE_BITS'(28)};
            8'd136: c = {1'b0, CODE_BITS'(29)};
            8'd228: c = {1'b0, CODE_BITS'(30)};
            8'd162: c = {1'b0, CODE_BITS'(31)};
            8'd152: c = {1'b0, CODE_BITS'(32)};
            8'd171: c = {1'b0, CODE_BITS'(33)};
            8'd190: c = {1'b0, CODE_BITS'(34)};
            default: ;
        endcase
        if (!c[CODE_BITS] && c[CODE_BITS-1:0] >= CODE_BITS'(ALPHABET_SIZE))
            c = {1'b1, {CODE_BITS{1'b0}}};
        return c;
    endfunction

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction
endpackage
`default_nettype wire

// ----- rtl/core/ltc_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ltc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/ltc_datapath.sv -----
// Datapath: letter mapping, counter memories, pair total and restoring divider.
// Depends on ltc_pkg and ltc_ram.
`timescale 1ns / 1ps
`default_nettype none
module ltc_datapath
    import ltc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    input  wire logic [1:0]            in_op,
    input  wire logic [7:0]            in_byte,
    input  wire logic [CODE_BITS-1:0]  in_a0,
    input  wire logic [CODE_BITS-1:0]  in_a1,
    input  wire logic [CODE_BITS-1:0]  in_a2,
    output logic [2:0]                 out_status,
    output logic [COUNT_BITS-1:0]      out_count,
    output logic [COUNT_BITS-1:0]      out_total,
    output logic [PCT_BITS-1:0]        out_pct
);
    logic [1:0]            op_reg;
    logic [7:0]            byte_reg;
    logic [CODE_BITS-1:0]  a0_reg, a1_reg, a2_reg;
    phase_t                phase_reg;
    logic [CODE_BITS-1:0]  older_reg, newer_reg;
    logic [COUNT_BITS-1:0] pair_total_reg;
    logic [TRI_AW-1:0]     clr_reg;
    logic [2:0]            status_reg;
    logic [2:0]            feed_st_reg;
    logic [COUNT_BITS-1:0] count_reg, total_reg;
    logic [COUNT_BITS-1:0] lat_count_reg, lat_total_reg;
    logic [PCT_BITS-1:0]   pct_reg;
    logic [DIVIDEND_BITS-1:0] rem_reg;
    logic [QUOT_BITS-1:0]  quot_reg;
    logic [4:0]            div_cnt_reg;

    logic [CODE_BITS:0]    code;
    logic                  valid_code;
    logic [PAIR_AW-1:0]    pair_idx, row_idx, rd_row;
    logic [TRI_AW-1:0]     tri_idx, rd_tri;
    logic                  idx01_ok, idx2_ok;
    logic                  tri_we, row_we, pair_we;
    logic [TRI_AW-1:0]     tri_addr;
    logic [PAIR_AW-1:0]    row_addr, pair_addr;
    logic [COUNT_BITS-1:0] tri_wd, row_wd, pair_wd, tri_rd, row_rd, pair_rd;
    logic [COUNT_BITS-1:0] sel_count, sel_total;
    logic [DIVIDEND_BITS:0] trial;

    assign code       = letter_code(byte_reg);
    assign valid_code = !code[CODE_BITS];
    assign pair_idx   = PAIR_AW'(older_reg * ALPHABET_SIZE) + PAIR_AW'(code[CODE_BITS-1:0]);
    assign row_idx    = PAIR_AW'(older_reg * ALPHABET_SIZE) + PAIR_AW'(newer_reg);
    assign tri_idx    = TRI_AW'(row_idx * ALPHABET_SIZE) + TRI_AW'(code[CODE_BITS-1:0]);
    assign idx01_ok   = a0_reg < CODE_BITS'(ALPHABET_SIZE) && a1_reg < CODE_BITS'(ALPHABET_SIZE);
    assign idx2_ok    = a2_reg < CODE_BITS'(ALPHABET_SIZE);
    assign rd_row     = PAIR_AW'(a0_reg * ALPHABET_SIZE) + PAIR_AW'(a1_reg);
    assign rd_tri     = TRI_AW'(rd_row * ALPHABET_SIZE) + TRI_AW'(a2_reg);

    // Feed words in the line phase touch trigram and row memories, in the
    // first-letter phase the pair memory.
    logic feed_tri, feed_pair;
    assign feed_tri  = op_reg == OP_FEED && byte_reg != LINE_END && valid_code
                       && phase_reg == PH_LINE;
    assign feed_pair = op_reg == OP_FEED && byte_reg != LINE_END && valid_code
                       && phase_reg == PH_FIRST;

    always_comb
    begin
        tri_addr  = (op_reg == OP_FEED) ? tri_idx : rd_tri;
        row_addr  = (op_reg == OP_FEED) ? row_idx : rd_row;
        pair_addr = (op_reg == OP_FEED) ? pair_idx : rd_row;
        tri_wd    = sat_inc(tri_rd);
        row_wd    = sat_inc(row_rd);
        pair_wd   = sat_inc(pair_rd);
        tri_we    = cmd.feed_write && feed_tri;
        row_we    = cmd.feed_write && feed_tri;
        pair_we   = cmd.feed_write && feed_pair;
        if (cmd.clear_step)
        begin
            tri_addr  = clr_reg;
            row_addr  = PAIR_AW'(clr_reg);
            pair_addr = PAIR_AW'(clr_reg);
            tri_wd    = '0;
            row_wd    = '0;
            pair_wd   = '0;
            tri_we    = 1'b1;
            row_we    = clr_reg < TRI_AW'(PAIRS);
            pair_we   = clr_reg < TRI_AW'(PAIRS);
        end
    end

    ltc_ram #(.WIDTH(COUNT_BITS), .DEPTH(TRIS)) u_tri (
        .clk(clk), .we(tri_we), .addr(tri_addr), .wdata(tri_wd), .rdata(tri_rd));
    ltc_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIRS)) u_row (
        .clk(clk), .we(row_we), .addr(row_addr), .wdata(row_wd), .rdata(row_rd));
    ltc_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIRS)) u_pair (
        .clk(clk), .we(pair_we), .addr(pair_addr), .wdata(pair_wd), .rdata(pair_rd));

    always_comb
    begin
        if (op_reg == OP_READ_TRI)
        begin
            sel_total = idx01_ok ? row_rd : '0;
            sel_count = (idx01_ok && idx2_ok) ? tri_rd : '0;
        end
        else
        begin
            sel_total = pair_total_reg;
            sel_count = idx01_ok ? pair_rd : '0;
        end
    end

    // The divisor sits 8 bits up so that 16 steps yield count*100*256/total.
    assign trial = {1'b0, rem_reg[DIVIDEND_BITS-2:0], 1'b0}
                   - {1'b0, 8'd0, lat_total_reg, 8'd0};

    assign stat.clear_done = clr_reg == TRI_AW'(TRIS - 1);
    assign stat.need_div   = sel_total != '0;
    assign stat.div_done   = div_cnt_reg == 5'(QUOT_BITS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SEEK;
            older_reg      <= '0;
            newer_reg      <= '0;
            pair_total_reg <= '0;
            clr_reg        <= '0;
            div_cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + TRI_AW'(1);
            end
            if (cmd.feed_write && op_reg == OP_FEED)
            begin
                if (byte_reg == LINE_END)
                begin
                    phase_reg <= PH_SEEK;
                end
                else if (valid_code)
                begin
                    case (phase_reg)
                        PH_FIRST:
                        begin
                            newer_reg      <= code[CODE_BITS-1:0];
                            pair_total_reg <= sat_inc(pair_total_reg);
                            phase_reg      <= PH_LINE;
                        end
                        PH_LINE:
                        begin
                            older_reg <= newer_reg;
                            newer_reg <= code[CODE_BITS-1:0];
                        end
                        default:
                        begin
                            older_reg <= code[CODE_BITS-1:0];
                            phase_reg <= PH_FIRST;
                        end
                    endcase
                end
            end
            if (cmd.read_latch)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            byte_reg <= in_byte;
            a0_reg   <= in_a0;
            a1_reg   <= in_a1;
            a2_reg   <= in_a2;
        end
        // The feed status follows the phase before this word updates it.
        if (cmd.feed_write)
        begin
            if (byte_reg == LINE_END) feed_st_reg <= ST_WAIT;
            else if (!valid_code) feed_st_reg <= ST_IGNORED;
            else if (phase_reg == PH_FIRST) feed_st_reg <= ST_PAIR;
            else if (phase_reg == PH_LINE) feed_st_reg <= ST_TRIGRAM;
            else feed_st_reg <= ST_WAIT;
        end
        if (cmd.read_latch)
        begin
            lat_count_reg <= sel_count;
            lat_total_reg <= sel_total;
            // Dividend count * 25600 = count * 100 shifted by 8; start with
            // count*100 and take 16 quotient bits, the low 8 are the fraction.
            rem_reg   <= DIVIDEND_BITS'(sel_count) * DIVIDEND_BITS'(100);
            quot_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            if (!trial[DIVIDEND_BITS])
            begin
                rem_reg  <= trial[DIVIDEND_BITS-1:0];
                quot_reg <= {quot_reg[QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[DIVIDEND_BITS-2:0], 1'b0};
                quot_reg <= {quot_reg[QUOT_BITS-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            case (op_reg)
                OP_FEED:
                begin
                    status_reg <= feed_st_reg;
                    count_reg  <= '0;
                    total_reg  <= '0;
                    pct_reg    <= '0;
                end
                OP_READ_TRI, OP_READ_PAIR:
                begin
                    if (lat_total_reg == '0)
                    begin
                        status_reg <= ST_READ_ZERO;
                        count_reg  <= '0;
                        total_reg  <= '0;
                        pct_reg    <= (op_reg == OP_READ_TRI) ? PCT_EMPTY_ROW : '0;
                    end
                    else
                    begin
                        status_reg <= ST_READ_OK;
                        count_reg  <= lat_count_reg;
                        total_reg  <= lat_total_reg;
                        pct_reg    <= (quot_reg > QUOT_BITS'(PCT_FULL)) ? PCT_FULL
                                      : quot_reg[PCT_BITS-1:0];
                    end
                end
                default:
                begin
                    status_reg <= ST_IGNORED;
                    count_reg  <= '0;
                    total_reg  <= '0;
                    pct_reg    <= '0;
                end
            endcase
        end
    end

    assign out_status = status_reg;
    assign out_count  = count_reg;
    assign out_total  = total_reg;
    assign out_pct    = pct_reg;
endmodule
`default_nettype wire

// ----- rtl/core/ltc_ctrl.sv -----
// Controller state machine: clearing pass, feed read-modify-write, read and divide.
// Depends on ltc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ltc_ctrl
    import ltc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire logic  [1:0] in_op,
    output logic       out_valid,
    input  wire logic  out_ready,
    output cmd_t       cmd,
    input  wire stat_t stat
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (in_op == OP_FEED) ? S_FEED_RD : S_READ_RD;
                end
            end
            S_FEED_RD: state_next = S_FEED_WR;
            S_FEED_WR:
            begin
                cmd.feed_write = 1'b1;
                state_next     = S_OUT;
            end
            S_READ_RD: state_next = S_READ_DATA;
            S_READ_DATA:
            begin
                cmd.read_latch = 1'b1;
                state_next     = stat.need_div ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        cmd.issue_read = state_reg == S_FEED_RD || state_reg == S_READ_RD;
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE) else $error("accept while busy");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready)) else $error("output overrun");
    a_feed_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.feed_write |-> $past(state_reg) == S_FEED_RD) else $error("write without read");
`endif
endmodule
`default_nettype wire

// ----- rtl/core/letter_trigram_counter_core.sv -----
// Top level of the letter trigram counter: controller plus datapath.
// Depends on ltc_pkg, ltc_ctrl, ltc_datapath.
//
// Channel  Dir  Fields (tdata/tuser from the lowest bit)
// s_axis   in   tdata: op[1:0] text_byte[9:2] first[15:10] second[21:16] third[27:22]
// m_axis   out  tdata: status[2:0] count[34:3] total[66:35] percent_q8[81:67]
//
// A feed word goes through read, modify-write and output states. A read goes
// through read, latch and output states, with the 16-step restoring divider
// between latch and output when the total is nonzero. After reset a clearing
// pass sweeps the trigram, row and pair memories, one entry per cycle, before
// any word is accepted. A stalled output holds the block in its output state.
`timescale 1ns / 1ps
`default_nettype none
module letter_trigram_counter_core
    import ltc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // op, text_byte, first, second, third
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [87:0]      m_axis_tdata    // status, count, total, percent_q8
);
    cmd_t  cmd;
    stat_t stat;
    logic [2:0]            st;
    logic [COUNT_BITS-1:0] cnt, tot;
    logic [PCT_BITS-1:0]   pct;

    ltc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tdata[1:0]), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .stat(stat));

    ltc_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_op(s_axis_tdata[1:0]), .in_byte(s_axis_tdata[9:2]),
        .in_a0(s_axis_tdata[15:10]), .in_a1(s_axis_tdata[21:16]),
        .in_a2(s_axis_tdata[27:22]),
        .out_status(st), .out_count(cnt), .out_total(tot), .out_pct(pct));

    assign m_axis_tdata = {6'd0, pct, tot, cnt, st};
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for letter_trigram_counter_core: streams text and read words,
// predicts every result with an in-bench trigram histogram and compares field by field.
// Depends on ltc_pkg and the letter_trigram_counter_core RTL.
`timescale 1ns / 1ps
module tb_top;
    import ltc_pkg::*;

    typedef struct packed {
        logic [14:0] pct;
        logic [31:0] total;
        logic [31:0] count;
        logic [2:0]  status;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [87:0] m_axis_tdata;

    letter_trigram_counter_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #4 clk = ~clk;

    // Histogram mirror.
    logic [1:0]  line_phase;
    logic [5:0]  prev2, prev1;
    logic [31:0] tri_hist [TRIS];
    logic [31:0] row_sum [PAIRS];
    logic [31:0] start_hist [PAIRS];
    logic [31:0] start_sum;

    result_t expected_q[$];
    int  errors = 0;
    int  cycles = 0;
    int  quiet_cnt = 0;
    bit  hold_off = 1'b0;
    bit  rx_quiet = 1'b0;
    bit  tx_pause = 1'b0;
    bit  gap_burst = 1'b1;

    function automatic int map_letter(input logic [7:0] b);
        logic [7:0] polish [9];
        polish = '{8'd165, 8'd134, 8'd169, 8'd136, 8'd228, 8'd162, 8'd152, 8'd171, 8'd190};
        if (b >= 8'd97 && b <= 8'd122) return b - 97;
        for (int i = 0; i < 9; i++)
            if (b == polish[i]) return 26 + i;
        return -1;
    endfunction

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [14:0] ratio_q8(input logic [31:0] c, input logic [31:0] t);
        logic [63:0] p;
        p = (64'(c) * 64'd25600) / 64'(t);
        return (p > 64'd25600) ? 15'd25600 : p[14:0];
    endfunction

    function automatic result_t histogram_step(input logic [31:0] w);
        result_t r;
        op_t op;
        logic [7:0] b;
        int a0, a1, a2, c, ri, pi;
        r = '0;
        op = op_t'(w[1:0]);
        b = w[9:2];
        a0 = w[15:10];
        a1 = w[21:16];
        a2 = w[27:22];
        r.status = ST_IGNORED;
        if (line_phase > 2) line_phase = PH_SEEK;
        case (op)
            OP_FEED: begin
                c = map_letter(b);
                if (b == LINE_END) begin
                    line_phase = PH_SEEK;
                    r.status = ST_WAIT;
                end
                else if (c < 0) r.status = ST_IGNORED;
                else if (line_phase == PH_SEEK) begin
                    prev2 = c;
                    line_phase = PH_FIRST;
                    r.status = ST_WAIT;
                end
                else if (line_phase == PH_FIRST) begin
                    pi = prev2 * ALPHABET_SIZE + c;
                    prev1 = c;
                    start_hist[pi] = bump(start_hist[pi]);
                    start_sum = bump(start_sum);
                    line_phase = PH_LINE;
                    r.status = ST_PAIR;
                end
                else begin
                    ri = prev2 * ALPHABET_SIZE + prev1;
                    tri_hist[ri * ALPHABET_SIZE + c] = bump(tri_hist[ri * ALPHABET_SIZE + c]);
                    row_sum[ri] = bump(row_sum[ri]);
                    prev2 = prev1;
                    prev1 = c;
                    r.status = ST_TRIGRAM;
                end
            end
            OP_READ_TRI: begin
                if (a0 < ALPHABET_SIZE && a1 < ALPHABET_SIZE) begin
                    ri = a0 * ALPHABET_SIZE + a1;
                    r.total = row_sum[ri];
                    if (a2 < ALPHABET_SIZE) r.count = tri_hist[ri * ALPHABET_SIZE + a2];
                end
                if (r.total == 0) begin
                    r.count = 0;
                    r.status = ST_READ_ZERO;
                    r.pct = PCT_EMPTY_ROW;
                end
                else begin
                    r.status = ST_READ_OK;
                    r.pct = ratio_q8(r.count, r.total);
                end
            end
            OP_READ_PAIR: begin
                if (a0 < ALPHABET_SIZE && a1 < ALPHABET_SIZE)
                    r.count = start_hist[a0 * ALPHABET_SIZE + a1];
                r.total = start_sum;
                if (r.total == 0) begin
                    r.count = 0;
                    r.status = ST_READ_ZERO;
                end
                else begin
                    r.status = ST_READ_OK;
                    r.pct = ratio_q8(r.count, r.total);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pack_word(input op_t op, input logic [7:0] b,
                                              input logic [5:0] f, input logic [5:0] s,
                                              input logic [5:0] t);
        return {4'b0, t, s, f, b, op};
    endfunction

    // Valid stays up between words of a burst; it drops only for a gap or a drain.
    task automatic send_word(input logic [31:0] w);
        if (gap_burst && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        expected_q.push_back(histogram_step(w));
    endtask

    task automatic feed(input logic [7:0] b);
        send_word(pack_word(OP_FEED, b, $urandom, $urandom, $urandom));
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed;
        logic [7:0] polish [9];
        polish = '{8'd165, 8'd134, 8'd169, 8'd136, 8'd228, 8'd162, 8'd152, 8'd171, 8'd190};
        // Reads on empty tables first.
        send_word(pack_word(OP_READ_TRI, 8'h00, 6'd0, 6'd0, 6'd0));
        send_word(pack_word(OP_READ_PAIR, 8'hFF, 6'd34, 6'd34, 6'd63));
        feed(8'd97);
        feed(LINE_END);          // abandons a lone first letter
        feed(8'd122);
        feed(8'd0);              // unmapped byte
        feed(8'd255);
        for (int i = 0; i < 9; i++) feed(polish[i]);
        feed(LINE_END);
        send_word(pack_word(OP_READ_TRI, 8'h00, 6'd25, 6'd26, 6'd27));
        send_word(pack_word(OP_READ_TRI, 8'h00, 6'd25, 6'd26, 6'd63));
        send_word(pack_word(OP_READ_TRI, 8'h00, 6'd63, 6'd26, 6'd27));
        send_word(pack_word(OP_READ_PAIR, 8'h00, 6'd25, 6'd26, 6'd0));
        send_word(pack_word(OP_READ_PAIR, 8'h00, 6'd35, 6'd63, 6'd0));
        send_word(pack_word(OP_NONE, 8'hA5, 6'd63, 6'd63, 6'd63));
        send_word(pack_word(OP_NONE, 8'h5A, 6'd0, 6'd0, 6'd0));
    endtask

    task automatic test_random_text;
        logic [7:0] common [10];
        int n;
        common = '{8'd97, 8'd98, 8'd99, 8'd101, 8'd165, 8'd134, 8'd169, 8'd190, 8'd122, 8'd110};
        n = 0;
        while (n < 1000) begin
            int k;
            k = $urandom_range(0, 99);
            if (k < 60) feed(common[$urandom_range(0, 9)]);
            else if (k < 70) feed(LINE_END);
            else if (k < 78) feed($urandom);
            else if (k < 88)
                send_word(pack_word(OP_READ_TRI, $urandom, $urandom_range(0, 9) == 0 ?
                    6'($urandom) : 6'(map_letter(common[$urandom_range(0, 9)])),
                    6'(map_letter(common[$urandom_range(0, 9)])),
                    $urandom_range(0, 9) == 0 ? 6'($urandom) :
                    6'(map_letter(common[$urandom_range(0, 9)]))));
            else if (k < 97)
                send_word(pack_word(OP_READ_PAIR, $urandom,
                    6'(map_letter(common[$urandom_range(0, 9)])),
                    $urandom_range(0, 9) == 0 ? 6'($urandom) :
                    6'(map_letter(common[$urandom_range(0, 9)])), $urandom));
            else send_word(pack_word(OP_NONE, $urandom, $urandom, $urandom, $urandom));
            n++;
        end
    endtask

    task automatic test_backpressure;
        // Receiver goes quiet while the sender keeps offering words.
        gap_burst = 1'b0;
        hold_off = 1'b1;
        for (int i = 0; i < 60; i++) feed($urandom_range(0, 3) == 0 ? 8'd10 : 8'd97 + 8'($urandom_range(0, 3)));
        drain();
        gap_burst = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(pack_word(OP_READ_TRI, 8'h00, $urandom_range(0, 3), $urandom_range(0, 3),
                                $urandom_range(0, 3)));
        drain();
        for (int i = 0; i < 40; i++)
            send_word(pack_word(OP_READ_PAIR, 8'h00, $urandom_range(0, 3), $urandom_range(0, 3), 6'd0));
    endtask

    // Receiver: stall pattern plus one long quiet stretch of fixed length on request.
    always @(posedge clk) begin
        if (hold_off && !rx_quiet) begin
            rx_quiet  <= 1'b1;
            hold_off  <= 1'b0;
            quiet_cnt <= 400;
        end
        if (rx_quiet) begin
            m_axis_tready <= 1'b0;
            if (quiet_cnt <= 1) rx_quiet <= 1'b0;
            else quiet_cnt <= quiet_cnt - 1;
        end
        else if (cycles % 2000 < 500) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk) begin
        result_t got, exp_r;
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[81:0];
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
            end
            else begin
                exp_r = expected_q.pop_front();
                if (got.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
                    errors++;
                end
                if (got.count !== exp_r.count) begin
                    $display("%0t: count expected %0d actual %0d", $time, exp_r.count, got.count);
                    errors++;
                end
                if (got.total !== exp_r.total) begin
                    $display("%0t: total expected %0d actual %0d", $time, exp_r.total, got.total);
                    errors++;
                end
                if (got.pct !== exp_r.pct) begin
                    $display("%0t: percent expected %0d actual %0d", $time, exp_r.pct, got.pct);
                    errors++;
                end
            end
        end
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        line_phase = PH_SEEK;
        prev2 = 0;
        prev1 = 0;
        start_sum = 0;
        for (int i = 0; i < TRIS; i++) tri_hist[i] = 0;
        for (int i = 0; i < PAIRS; i++) begin
            row_sum[i] = 0;
            start_hist[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        drain();
        test_random_text();
        drain();
        test_backpressure();
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
